// ===== src/smf_pkg.sv =====
package smf_pkg;

    localparam int MAX_WINDOW = 15;
    localparam int CW         = $clog2(MAX_WINDOW);
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
    localparam int CAP        = (MAX_WINDOW % 2 == 1) ? MAX_WINDOW : (MAX_WINDOW - 1);
    localparam int CFG_W      = 4;
    localparam int IDX_W      = 16;
    localparam int DATA_W     = 32;

    localparam logic [CFG_W-1:0] LEN_RESET = CFG_W'(3);

    typedef struct packed {
        logic signed [DATA_W-1:0] diameter;
        logic signed [DATA_W-1:0] sharpness;
        logic                     seq_start;
    } t_in_beat;

    typedef struct packed {
        logic signed [DATA_W-1:0] median_diameter;
        logic signed [DATA_W-1:0] median_sharpness;
        logic        [IDX_W-1:0]  center_index;
    } t_out_beat;

    typedef struct packed {
        logic signed [DATA_W-1:0] d;
        logic signed [DATA_W-1:0] s;
    } t_pair;

    typedef struct packed {
        logic          shift;
        logic          load;
        logic          run;
        logic [CW-1:0] step;
    } t_cell_ctl;

endpackage

// ===== src/smf_cell.sv =====
module smf_cell import smf_pkg::*; (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [CW-1:0]    i_pos,
    input  logic [CNT_W-1:0] i_len,
    input  logic [CW-1:0]    i_half,
    input  t_pair            i_shift_in,
    input  t_pair            i_ring_in,
    input  t_pair            i_probe_in,
    output t_pair            o_sample,
    output t_pair            o_probe,
    output logic             o_match_d,
    output logic             o_match_s
);

    t_pair         r_sample;
    t_pair         r_probe;
    logic [CW-1:0] r_rank_d;
    logic [CW-1:0] r_rank_s;

    logic [CW:0]   j_wide;
    logic [CW-1:0] j_pos;
    logic          in_win;
    logic          older;
    logic          hit_d;
    logic          hit_s;

    // window position of the sample the probe carries at this step
    always_comb begin
        if (i_ctl.step <= i_pos) begin
            j_wide = {1'b0, i_pos} - {1'b0, i_ctl.step};
        end else begin
            j_wide = {1'b0, i_pos} + (CW + 1)'(MAX_WINDOW) - {1'b0, i_ctl.step};
        end
    end

    assign j_pos  = j_wide[CW-1:0];
    assign in_win = CNT_W'(j_pos) < i_len;
    assign older  = j_pos < i_pos;

    // stable rank: equal values are ordered by window position
    assign hit_d = in_win && (($signed(r_probe.d) < $signed(r_sample.d)) ||
                              ((r_probe.d == r_sample.d) && older));
    assign hit_s = in_win && (($signed(r_probe.s) < $signed(r_sample.s)) ||
                              ((r_probe.s == r_sample.s) && older));

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_sample <= i_shift_in;
        end
        if (i_ctl.load) begin
            r_probe  <= i_ring_in;
            r_rank_d <= '0;
            r_rank_s <= '0;
        end else if (i_ctl.run) begin
            r_probe  <= i_probe_in;
            r_rank_d <= r_rank_d + CW'(hit_d);
            r_rank_s <= r_rank_s + CW'(hit_s);
        end
    end

    assign o_sample  = r_sample;
    assign o_probe   = r_probe;
    assign o_match_d = (CNT_W'(i_pos) < i_len) && (r_rank_d == i_half);
    assign o_match_s = (CNT_W'(i_pos) < i_len) && (r_rank_s == i_half);

endmodule

// ===== src/sliding_median_filter_two_channel.sv =====
// Two-channel running median over an odd window of paired Q16.16 samples.
// Input channel (i_in_*): one beat carries diameter, sharpness and seq_start.
// Output channel (o_out_*): one beat carries both medians and the index of
// the window's centre sample. Config channel (i_cfg_*): window length,
// always ready; even lengths round up to the next odd one.
// The window is a row of cells that shift on each input beat. Each cell ranks
// its own sample by comparing against probes that circulate around the row,
// one step per cycle, so a beat that produces a result passes through the
// load, run and emit states before the result is registered at the output.
// A beat with no result (window not yet full) leaves the block idle. One beat
// is processed at a time; the block accepts no new beat while it works on one.
// If the receiver stalls, the result waits in the output register and the
// block holds the finished median until the register frees, then it returns
// to accepting input.
// Reset clears the fill count, the sample index and the state, and sets the
// window length to 3. seq_start restarts the sequence at index 0.
module sliding_median_filter_two_channel import smf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_beat         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_beat        o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_RUN  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [CFG_W-1:0] r_cfg;
    logic [CNT_W-1:0] r_fill;
    logic [IDX_W-1:0] r_index;
    logic [CNT_W-1:0] r_len;
    logic [CW-1:0]    r_half;
    logic [IDX_W-1:0] r_center;
    logic [CW-1:0]    r_step;
    logic             r_out_valid;
    t_out_beat        r_out;

    logic             in_acc;
    logic             emit_go;
    logic [CFG_W-1:0] len_odd;
    logic [CNT_W-1:0] len_eff;
    logic [CNT_W-1:0] n_fill;
    logic [IDX_W-1:0] cur_index;
    logic [CNT_W-1:0] len_m1;
    logic [CW-1:0]    half_eff;
    t_cell_ctl        ctl;
    t_pair            new_pair;
    t_pair            sample [MAX_WINDOW];
    t_pair            probe  [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] match_d;
    logic [MAX_WINDOW-1:0] match_s;
    logic signed [DATA_W-1:0] med_d;
    logic signed [DATA_W-1:0] med_s;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign emit_go     = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);

    // effective window length: round up to odd, clamp to capacity
    always_comb begin
        len_odd = {r_cfg[CFG_W-1:1], 1'b1};
        if (int'(len_odd) > CAP) begin
            len_eff = CNT_W'(CAP);
        end else begin
            len_eff = CNT_W'(len_odd);
        end
    end

    assign len_m1   = len_eff - CNT_W'(1);
    assign half_eff = CW'(len_m1 >> 1);

    always_comb begin
        if (i_in_data.seq_start) begin
            n_fill    = CNT_W'(1);
            cur_index = '0;
        end else begin
            n_fill    = (r_fill < CNT_W'(MAX_WINDOW)) ? r_fill + CNT_W'(1) : r_fill;
            cur_index = r_index;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (n_fill >= len_eff)) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = S_RUN;
            end
            S_RUN: begin
                if (r_step == CW'(MAX_WINDOW - 1)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (emit_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= LEN_RESET;
            r_fill      <= '0;
            r_index     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end
            if (in_acc) begin
                r_fill  <= n_fill;
                r_index <= cur_index + IDX_W'(1);
            end
            if (r_state == S_LOAD) begin
                r_step <= CW'(1);
            end else if (r_state == S_RUN) begin
                r_step <= r_step + CW'(1);
            end
            if (emit_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_len    <= len_eff;
            r_half   <= half_eff;
            r_center <= cur_index - IDX_W'(half_eff);
        end
        if (emit_go) begin
            r_out.median_diameter  <= med_d;
            r_out.median_sharpness <= med_s;
            r_out.center_index     <= r_center;
        end
    end

    assign ctl.shift = in_acc;
    assign ctl.load  = (r_state == S_LOAD);
    assign ctl.run   = (r_state == S_RUN);
    assign ctl.step  = r_step;

    assign new_pair.d = i_in_data.diameter;
    assign new_pair.s = i_in_data.sharpness;

    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        smf_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (ctl),
            .i_pos      (CW'(g)),
            .i_len      (r_len),
            .i_half     (r_half),
            .i_shift_in ((g == 0) ? new_pair : sample[(g + MAX_WINDOW - 1) % MAX_WINDOW]),
            .i_ring_in  (sample[(g + MAX_WINDOW - 1) % MAX_WINDOW]),
            .i_probe_in (probe[(g + MAX_WINDOW - 1) % MAX_WINDOW]),
            .o_sample   (sample[g]),
            .o_probe    (probe[g]),
            .o_match_d  (match_d[g]),
            .o_match_s  (match_s[g])
        );
    end

    // exactly one cell per channel holds the median rank
    always_comb begin
        med_d = '0;
        med_s = '0;
        for (int k = 0; k < MAX_WINDOW; k++) begin
            med_d = med_d | (match_d[k] ? sample[k].d : '0);
            med_s = med_s | (match_s[k] ? sample[k].s : '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_one_median: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> ($onehot(match_d) && $onehot(match_s)))
        else $error("median rank not unique");

    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(MAX_WINDOW))
        else $error("fill count above window capacity");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.seq_start) |=> (r_index == IDX_W'(1) && r_fill == CNT_W'(1)))
        else $error("sequence start did not restart the window");

    a_odd_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_len[0] == 1'b1))
        else $error("even window length in use");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |=> !$rose(r_fill == '0))
        else $error("window cleared while ranking");

endmodule
